// File: hw/rtl/rlfr_pkg.sv
// Shared types, codes and frame constants of the reader link frame receiver.
`timescale 1ns / 1ps

package rlfr_pkg;

    // Item selector carried on s_tuser
    localparam logic [1:0] FN_START = 2'd0;
    localparam logic [1:0] FN_BYTE  = 2'd1;
    localparam logic [1:0] FN_TICK  = 2'd2;
    localparam logic [1:0] FN_NONE  = 2'd3;

    // Exchange status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD_ACK  = 3'd1;
    localparam logic [2:0] ST_BAD_PRE  = 3'd2;
    localparam logic [2:0] ST_BAD_LCS  = 3'd3;
    localparam logic [2:0] ST_TOO_LONG = 3'd4;
    localparam logic [2:0] ST_BAD_DCS  = 3'd5;
    localparam logic [2:0] ST_BAD_POST = 3'd6;
    localparam logic [2:0] ST_TIMEOUT  = 3'd7;

    // Configuration register indexes
    localparam int          CFG_IDX_W       = 8;
    localparam int          CFG_DATA_W      = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DATA_LEN  = 8'd1;

    localparam logic [15:0] TIMEOUT_RESET  = 16'd1000;
    localparam logic [15:0] MAX_LEN_RESET  = 16'd512;
    localparam logic [15:0] TICKS_SAT      = 16'hFFFF;

    // Group lengths
    localparam logic [15:0] ACK_LEN     = 16'd7;
    localparam logic [15:0] HEADER_LEN  = 16'd6;
    localparam logic [15:0] PRE_LEN     = 16'd3;
    localparam logic [15:0] LEN_HI_POS  = 16'd3;
    localparam logic [15:0] LEN_LO_POS  = 16'd4;

    typedef enum logic [4:0] {
        PH_IDLE    = 5'b00001,
        PH_ACK     = 5'b00010,
        PH_HEADER  = 5'b00100,
        PH_DATA    = 5'b01000,
        PH_TRAILER = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [15:0] timeout_ticks;
        logic [15:0] max_data_len;
    } cfg_t;

    typedef struct packed {
        logic        is_status;
        logic [7:0]  data_byte;
        logic [2:0]  status_code;
        logic [15:0] frame_length;
    } result_t;

    // Expected ACK frame: 00 00 FF 00 00 FF 00
    function automatic logic [7:0] ack_byte(input logic [2:0] idx);
        logic [7:0] v;
        case (idx)
            3'd2, 3'd5: v = 8'hFF;
            default:    v = 8'h00;
        endcase
        return v;
    endfunction

    // Expected preamble: 00 00 FF
    function automatic logic [7:0] pre_byte(input logic [1:0] idx);
        logic [7:0] v;
        case (idx)
            2'd2:    v = 8'hFF;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

// File: hw/rtl/reader_link_frame_receiver_core.sv
// Top level of the reader link frame receiver: input stage, parser, result queue.
`timescale 1ns / 1ps

// Channel   Dir  Ports                                Beat contents (low bit up)
// s_        in   s_tvalid s_tready s_tdata s_tuser    tdata: rx_byte[7:0]; tuser: func[1:0]
// m_        out  m_tvalid m_tready m_tdata m_tuser    tdata: data_byte, status_code,
//                                                     frame_length, 5 zero bits; tuser: is_status
// cfg_      in   cfg_valid cfg_ready cfg_index cfg_data  index 0 timeout_ticks, 1 max_data_len
//
// One beat per cycle sustained while the queue has room: a beat is held in the input register,
// and the parser updates its state and decodes the result into the queue as the beat leaves it.
// A result reaches m_ through the input register and then a result queue entry.
// The two-entry result queue keeps s_ flowing while a result waits on m_tready; s_ stalls
// only once both queue entries are occupied.
// Reset (aresetn low, synchronous) empties both stages, puts the parser in idle and
// loads timeout_ticks = 1000, max_data_len = 512. cfg_ready is always high.

module reader_link_frame_receiver_core
    import rlfr_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] rx_byte
    input  logic [1:0]            s_tuser,   // [1:0] func

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata,   // [7:0] data_byte, [10:8] status_code,
                                             // [26:11] frame_length, [31:27] zero
    output logic                  m_tuser,   // [0] is_status

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Input register
    logic       in_valid_reg;
    logic [1:0] in_func_reg;
    logic [7:0] in_byte_reg;

    logic       step;
    logic       q_full;
    logic       res_valid;
    result_t    res;
    result_t    head;
    cfg_t       cfg;

    // Advance the held beat whenever the queue has room for a possible result
    assign step     = in_valid_reg && !q_full;
    assign s_tready = !in_valid_reg || step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    // Payload holds when no new beat is taken
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_func_reg <= s_tuser;
            in_byte_reg <= s_tdata;
        end
    end

    assign cfg_ready = 1'b1;

    rlfr_cfg_regs u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    rlfr_frame_fsm u_fsm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .func      (in_func_reg),
        .rx_byte   (in_byte_reg),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res)
    );

    rlfr_out_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (step && res_valid),
        .push_data (res),
        .full      (q_full),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (head)
    );

    assign m_tuser = head.is_status;
    assign m_tdata = {5'b00000, head.frame_length, head.status_code, head.data_byte};

endmodule

// File: hw/rtl/rlfr_cfg_regs.sv
// Configuration registers: timeout ticks and maximum data length.
`timescale 1ns / 1ps

module rlfr_cfg_regs
    import rlfr_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.timeout_ticks <= TIMEOUT_RESET;
            cfg_reg.max_data_len  <= MAX_LEN_RESET;
        end else if (wr_en) begin
            case (wr_index)
                CFG_TIMEOUT_TICKS: cfg_reg.timeout_ticks <= wr_data;
                CFG_MAX_DATA_LEN:  cfg_reg.max_data_len  <= wr_data;
                default: begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: hw/rtl/rlfr_frame_fsm.sv
// Frame parser: phase state, group counters, checksums and result decode.
`timescale 1ns / 1ps

module rlfr_frame_fsm
    import rlfr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step,
    input  logic [1:0] func,
    input  logic [7:0] rx_byte,
    input  cfg_t       cfg,
    output logic       res_valid,
    output result_t    res
);

    phase_t      phase_reg, phase_next;
    logic [15:0] pos_reg, pos_next;
    logic [15:0] hlen_reg, hlen_next;
    logic        mism_reg, mism_next;
    logic [7:0]  sum_reg, sum_next;
    logic [15:0] ticks_reg, ticks_next;

    logic [15:0] pos_inc;
    logic [15:0] ticks_inc;
    logic        mism_hit;
    logic [7:0]  sum_add;
    logic [15:0] hlen_upd;

    always_comb begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        hlen_next  = hlen_reg;
        mism_next  = mism_reg;
        sum_next   = sum_reg;
        ticks_next = ticks_reg;

        pos_inc   = pos_reg + 16'd1;
        ticks_inc = (ticks_reg == TICKS_SAT) ? ticks_reg : ticks_reg + 16'd1;
        sum_add   = sum_reg + rx_byte;
        mism_hit  = 1'b0;
        hlen_upd  = hlen_reg;

        res_valid        = 1'b0;
        res.is_status    = 1'b1;
        res.data_byte    = 8'h00;
        res.status_code  = ST_OK;
        res.frame_length = hlen_reg;

        if (func == FN_START) begin
            phase_next = PH_ACK;
            pos_next   = '0;
            hlen_next  = '0;
            mism_next  = 1'b0;
            sum_next   = '0;
            ticks_next = '0;
        end else if (phase_reg == PH_IDLE || func == FN_NONE) begin
            // ignore bytes and ticks outside an exchange, and FN_NONE items at all times
        end else if (func == FN_TICK) begin
            ticks_next = ticks_inc;
            if (ticks_inc >= cfg.timeout_ticks) begin
                res_valid       = 1'b1;
                res.status_code = ST_TIMEOUT;
                phase_next      = PH_IDLE;
            end
        end else if (ticks_reg >= cfg.timeout_ticks) begin
            res_valid       = 1'b1;
            res.status_code = ST_TIMEOUT;
            phase_next      = PH_IDLE;
        end else begin
            case (phase_reg)
                PH_ACK: begin
                    mism_hit  = mism_reg | (rx_byte != ack_byte(pos_reg[2:0]));
                    mism_next = mism_hit;
                    pos_next  = pos_inc;
                    if (pos_inc >= ACK_LEN) begin
                        if (mism_hit) begin
                            res_valid       = 1'b1;
                            res.status_code = ST_BAD_ACK;
                            phase_next      = PH_IDLE;
                        end else begin
                            phase_next = PH_HEADER;
                            pos_next   = '0;
                            mism_next  = 1'b0;
                            sum_next   = '0;
                            ticks_next = '0;
                        end
                    end
                end
                PH_HEADER: begin
                    mism_hit = mism_reg;
                    if (pos_reg < PRE_LEN) begin
                        mism_hit = mism_reg | (rx_byte != pre_byte(pos_reg[1:0]));
                        sum_add  = sum_reg;
                    end else if (pos_reg == LEN_HI_POS) begin
                        hlen_upd = {rx_byte, 8'h00};
                    end else if (pos_reg == LEN_LO_POS) begin
                        hlen_upd = hlen_reg | {8'h00, rx_byte};
                    end
                    mism_next = mism_hit;
                    sum_next  = sum_add;
                    hlen_next = hlen_upd;
                    pos_next  = pos_inc;
                    res.frame_length = hlen_upd;
                    if (pos_inc >= HEADER_LEN) begin
                        if (mism_hit) begin
                            res_valid       = 1'b1;
                            res.status_code = ST_BAD_PRE;
                            phase_next      = PH_IDLE;
                        end else if (sum_add != 8'h00) begin
                            res_valid       = 1'b1;
                            res.status_code = ST_BAD_LCS;
                            phase_next      = PH_IDLE;
                        end else if (hlen_upd > cfg.max_data_len) begin
                            res_valid       = 1'b1;
                            res.status_code = ST_TOO_LONG;
                            phase_next      = PH_IDLE;
                        end else begin
                            // empty payload skips straight to the trailer
                            phase_next = (hlen_upd == 16'd0) ? PH_TRAILER : PH_DATA;
                            pos_next   = '0;
                            mism_next  = 1'b0;
                            sum_next   = '0;
                            ticks_next = '0;
                        end
                    end
                end
                PH_DATA: begin
                    sum_next      = sum_add;
                    pos_next      = pos_inc;
                    res_valid     = 1'b1;
                    res.is_status = 1'b0;
                    res.data_byte = rx_byte;
                    if (pos_inc >= hlen_reg) begin
                        // keep the data sum for the checksum byte
                        phase_next = PH_TRAILER;
                        pos_next   = '0;
                        mism_next  = 1'b0;
                        ticks_next = '0;
                    end
                end
                PH_TRAILER: begin
                    if (pos_reg == 16'd0) begin
                        mism_next = (sum_add != 8'h00);
                        pos_next  = 16'd1;
                    end else begin
                        res_valid  = 1'b1;
                        phase_next = PH_IDLE;
                        if (mism_reg) begin
                            res.status_code = ST_BAD_DCS;
                        end else if (rx_byte != 8'h00) begin
                            res.status_code = ST_BAD_POST;
                        end else begin
                            res.status_code = ST_OK;
                        end
                    end
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            pos_reg   <= '0;
            hlen_reg  <= '0;
            mism_reg  <= 1'b0;
            sum_reg   <= '0;
            ticks_reg <= '0;
        end else if (step) begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            hlen_reg  <= hlen_next;
            mism_reg  <= mism_next;
            sum_reg   <= sum_next;
            ticks_reg <= ticks_next;
        end
    end

    a_data_only_in_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && res_valid && !res.is_status) |-> (phase_reg == PH_DATA))
        else $error("data beat produced outside the data phase");

    a_status_ends_exchange: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && res_valid && res.is_status) |=> (phase_reg == PH_IDLE))
        else $error("status beat did not return the parser to idle");

    a_group_position_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ((phase_reg == PH_ACK) |-> (pos_reg < ACK_LEN)) and
        ((phase_reg == PH_HEADER) |-> (pos_reg < HEADER_LEN)) and
        ((phase_reg == PH_TRAILER) |-> (pos_reg < 16'd2)))
        else $error("byte position ran past the end of its group");

endmodule

// File: hw/rtl/rlfr_out_queue.sv
// Two-entry result queue that decouples the parser from the master side.
`timescale 1ns / 1ps

module rlfr_out_queue
    import rlfr_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  result_t push_data,
    output logic    full,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    result_t    entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != 2'd0);
    assign full      = (count_reg == 2'd2);
    assign out_data  = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full))
        else $error("result pushed into a full queue");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3)
        else $error("queue count out of range");

    a_held_head: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
        else $error("stalled head beat changed");

endmodule
